// File: sv/acpd_pkg.sv
// Shared types, constants and codes of the AC phase-angle dimmer.
package acpd_pkg;

  localparam int CHANNELS_DEF = 8;
  localparam int GATE_W       = 8;
  localparam int CH_W         = 3;
  localparam int PCT_W        = 8;
  localparam int US_W         = 16;
  localparam int CNT_W        = 17;
  localparam int PROD_W       = 23;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Reset values of the configuration registers.
  localparam logic [US_W-1:0] LINE_PERIOD_RST = 16'd10000;
  localparam logic [US_W-1:0] ZERO_PULSE_RST  = 16'd0;

  // Percent thresholds of the level bands.
  localparam logic [PCT_W-1:0] PCT_OFF_BELOW = 8'd10;
  localparam logic [PCT_W-1:0] PCT_ON_ABOVE  = 8'd90;
  localparam logic [PCT_W-1:0] PCT_FULL      = 8'd100;

  // Floor division by 100 as a multiply by ceil(2^30 / 100) and a shift.
  // Exact for every product below 2^23.
  localparam int               RECIP_SHIFT = 30;
  localparam int               RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_M   = 24'd10737419;

  // Item commands.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_SET  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PULSE  = 1'b1;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_ON      = 2'd1,
    MODE_DELAYED = 2'd2
  } acpd_mode_t;

  typedef struct packed {
    logic             cmd;
    logic             zero_level;
    logic [US_W-1:0]  elapsed_us;
    logic [CH_W-1:0]  channel;
    logic [PCT_W-1:0] percent;
  } acpd_in_t;

  typedef struct packed {
    logic [GATE_W-1:0] gate_levels;
  } acpd_out_t;

  // Contents of the input register handed to the update stage.
  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic              zero_level;
    logic [US_W-1:0]   elapsed_us;
    logic [CH_W-1:0]   channel;
    acpd_mode_t        band;
    logic [PROD_W-1:0] product;
  } acpd_stage_t;

  // Status of the update stage.
  typedef struct packed {
    logic advance;
    logic zero_rise;
    logic count_zero;
  } acpd_status_t;

endpackage

// File: sv/acpd_stream_if.sv
// Valid/ready stream interface carrying one payload of type T per transfer.
interface acpd_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/acpd_front.sv
// Input register: takes items, sorts the level into its band and forms the delay product.
module acpd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  acpd_stream_if.sink                   in_if,
  input  logic [acpd_pkg::US_W-1:0]     line_period_us,
  input  acpd_pkg::acpd_status_t        status_i,
  output acpd_pkg::acpd_stage_t         stage_o
);
  import acpd_pkg::*;

  logic              s1_valid_r;
  logic              cmd_r;
  logic              zero_level_r;
  logic [US_W-1:0]   elapsed_r;
  logic [CH_W-1:0]   channel_r;
  acpd_mode_t        band_r;
  logic [PROD_W-1:0] product_r;

  acpd_mode_t        band_nxt;
  logic [6:0]        diff;
  logic [PROD_W-1:0] product_nxt;
  logic              take;

  // The register frees up when empty or when its item moves on this cycle.
  assign in_if.ready = !s1_valid_r || status_i.advance;
  assign take        = in_if.valid && in_if.ready;

  always_comb begin
    if (in_if.data.percent < PCT_OFF_BELOW) begin
      band_nxt = MODE_OFF;
    end else if (in_if.data.percent > PCT_ON_ABOVE) begin
      band_nxt = MODE_ON;
    end else begin
      band_nxt = MODE_DELAYED;
    end
    diff        = 7'(PCT_FULL - in_if.data.percent);
    product_nxt = {16'b0, diff} * {7'b0, line_period_us};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r        <= in_if.data.cmd;
      zero_level_r <= in_if.data.zero_level;
      elapsed_r    <= in_if.data.elapsed_us;
      channel_r    <= in_if.data.channel;
      band_r       <= band_nxt;
      product_r    <= product_nxt;
    end
  end

  assign stage_o = '{valid:      s1_valid_r,
                     cmd:        cmd_r,
                     zero_level: zero_level_r,
                     elapsed_us: elapsed_r,
                     channel:    channel_r,
                     band:       band_r,
                     product:    product_r};
endmodule

// File: sv/acpd_core.sv
// Update stage: channel table, crossing counter, gate state and result register.
module acpd_core #(
  parameter int CHANNELS = acpd_pkg::CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  acpd_pkg::acpd_stage_t         stage_i,
  input  logic [acpd_pkg::US_W-1:0]     zero_pulse_us,
  acpd_stream_if.source                 out_if,
  output acpd_pkg::acpd_status_t        status_o
);
  import acpd_pkg::*;

  localparam int SCALED_W = PROD_W + RECIP_W;

  acpd_mode_t         mode_r  [CHANNELS];
  acpd_mode_t         mode_nxt[CHANNELS];
  logic [CNT_W-1:0]   delay_r  [CHANNELS];
  logic [CNT_W-1:0]   delay_nxt[CHANNELS];
  logic [CHANNELS-1:0] gate_r, gate_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               lastz_r, lastz_nxt;
  logic               out_valid_r;
  logic [GATE_W-1:0]  out_data_r;

  logic                advance;
  logic                rise;
  logic [SCALED_W-1:0] scaled;
  logic [CNT_W-1:0]    quot;
  logic [CNT_W-1:0]    dly;
  logic [CNT_W:0]      cnt_sum;
  logic [CNT_W-1:0]    cnt_tick;
  logic [GATE_W-1:0]   gate_byte;

  assign advance = stage_i.valid && (!out_valid_r || out_if.ready);
  assign rise    = stage_i.zero_level && !lastz_r;

  always_comb begin
    scaled   = {{RECIP_W{1'b0}}, stage_i.product} * {{PROD_W{1'b0}}, RECIP_M};
    quot     = scaled[SCALED_W-1:RECIP_SHIFT];
    dly      = quot + {2'b0, zero_pulse_us[US_W-1:1]};
    cnt_sum  = {1'b0, cnt_r} + {2'b0, stage_i.elapsed_us};
    if (rise) begin
      cnt_tick = '0;
    end else if (cnt_sum[CNT_W]) begin
      cnt_tick = COUNT_MAX;
    end else begin
      cnt_tick = cnt_sum[CNT_W-1:0];
    end

    mode_nxt  = mode_r;
    delay_nxt = delay_r;
    gate_nxt  = gate_r;
    cnt_nxt   = cnt_r;
    lastz_nxt = lastz_r;

    if (advance) begin
      if (stage_i.cmd == CMD_SET) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (32'(stage_i.channel) == i) begin
            unique case (stage_i.band)
              MODE_DELAYED: begin
                delay_nxt[i] = dly;
                mode_nxt[i]  = (dly == '0) ? MODE_ON : MODE_DELAYED;
              end
              MODE_ON: begin
                delay_nxt[i] = '0;
                mode_nxt[i]  = MODE_ON;
              end
              default: begin
                delay_nxt[i] = '0;
                mode_nxt[i]  = MODE_OFF;
              end
            endcase
          end
        end
      end else begin
        cnt_nxt   = cnt_tick;
        lastz_nxt = stage_i.zero_level;
        for (int i = 0; i < CHANNELS; i++) begin
          unique case (mode_r[i])
            MODE_ON: gate_nxt[i] = 1'b1;
            MODE_DELAYED: begin
              if (cnt_tick == '0) begin
                gate_nxt[i] = 1'b0;
              end else if (cnt_tick >= delay_r[i]) begin
                gate_nxt[i] = 1'b1;
              end
            end
            default: gate_nxt[i] = 1'b0;
          endcase
        end
      end
    end
  end

  for (genvar g = 0; g < GATE_W; g++) begin : g_byte
    if (g < CHANNELS) begin : g_used
      assign gate_byte[g] = gate_nxt[g];
    end else begin : g_unused
      assign gate_byte[g] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        mode_r[i]  <= MODE_OFF;
        delay_r[i] <= '0;
      end
      gate_r      <= '0;
      cnt_r       <= '0;
      lastz_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      delay_r <= delay_nxt;
      gate_r  <= gate_nxt;
      cnt_r   <= cnt_nxt;
      lastz_r <= lastz_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
        out_data_r  <= gate_byte;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.data.gate_levels = out_data_r;

  assign status_o = '{advance:    advance,
                      zero_rise:  advance && (stage_i.cmd == CMD_TICK) && rise,
                      count_zero: (cnt_r == '0)};
endmodule

// File: sv/ac_phase_angle_dimmer_core.sv
// Top level of the multi-channel AC phase-angle dimmer.
//
// Usage: items arrive on in_if. A set item (cmd set) gives one channel a
// brightness in percent; below 10 the channel is off, above 90 it is fully
// on, and in between it fires after (100 - percent) * line period / 100 plus
// half the zero-cross pulse width, in microseconds. A tick item (cmd tick)
// carries the sampled zero-cross level and the microseconds since the last
// tick; a rising zero-cross level restarts the crossing counter. Every item
// yields exactly one transfer on out_if with the gate levels of all channels.
// Configuration writes on the cfg_ port take effect at once; the user must
// issue them only while no item is in flight, which the block does not check.
// An item passes the input register, then the output register. Throughput
// is one item per cycle while out_if is ready: the input register and
// the output register form a two-stage pipeline, the set path's multiply
// sits ahead of the input register and the divide-by-100 after it.
// Reset (synchronous, active low) clears all channels to off, the counter,
// the stored zero-cross level, the gates and both pipeline stages, and loads
// a line period of 10000 us and a pulse width of 0. When the receiver stalls
// the result holds and the input register still takes one more item.
module ac_phase_angle_dimmer_core #(
  parameter int CHANNELS = acpd_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  acpd_stream_if.sink                       in_if,
  acpd_stream_if.source                     out_if,
  input  logic                              cfg_we,
  input  logic [acpd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [acpd_pkg::US_W-1:0]         cfg_wdata
);
  import acpd_pkg::*;

  logic [US_W-1:0] line_period_r;
  logic [US_W-1:0] zero_pulse_r;
  acpd_stage_t     stage;
  acpd_status_t    status;

  // Configuration registers; both indexes map to a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_period_r <= LINE_PERIOD_RST;
      zero_pulse_r  <= ZERO_PULSE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_PERIOD: line_period_r <= cfg_wdata;
        REG_ZERO_PULSE:  zero_pulse_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register, level band decode and the (100 - percent) * period product.
  acpd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_if          (in_if),
    .line_period_us (line_period_r),
    .status_i       (status),
    .stage_o        (stage)
  );

  // Channel table, crossing counter, gate update and the output register.
  acpd_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .stage_i       (stage),
    .zero_pulse_us (zero_pulse_r),
    .out_if        (out_if),
    .status_o      (status)
  );

  // Each item moving out of the input register loads the output register.
  a_advance_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    status.advance |=> out_if.valid)
    else $error("result register not loaded after an item advanced");

  // The output register only becomes valid from an advancing item.
  a_out_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(status.advance))
    else $error("result appeared without an item");

  // A set item never moves the gates.
  a_set_keeps_gates: assert property (@(posedge clk) disable iff (!rst_n)
    status.advance && (stage.cmd == CMD_SET)
      |=> out_if.data.gate_levels == $past(out_if.data.gate_levels))
    else $error("set item changed the gate levels");

  // A rising zero-cross level on a tick restarts the crossing counter.
  a_rise_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    status.zero_rise |=> status.count_zero)
    else $error("crossing counter not restarted on a rising zero-cross");
endmodule

// File: sim/acpd_gate_checker.sv
// Scoreboard for the dimmer core: predicts gate levels per transfer and checks the results.
`timescale 1ns / 100ps

module acpd_gate_checker #(
  parameter int CHANNELS = acpd_pkg::CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  acpd_pkg::acpd_in_t             in_item,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  acpd_pkg::acpd_out_t            out_item,
  input  logic                           cfg_we,
  input  logic [acpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acpd_pkg::US_W-1:0]      cfg_wdata,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);
  import acpd_pkg::*;

  // Shadow copy of the registers and of the channel state.
  logic [US_W-1:0]   line_period;
  logic [US_W-1:0]   zero_pulse;
  acpd_mode_t        chan_mode [CHANNELS];
  logic [CNT_W-1:0]  fire_delay [CHANNELS];
  logic [GATE_W-1:0] gates;
  logic [CNT_W-1:0]  since_cross;
  logic              last_zero;

  acpd_out_t gate_expect_q [$];
  acpd_out_t want;
  int        mismatches = 0;
  int        compared = 0;

  // A set item only moves the named channel into a band and latches its delay.
  function automatic void apply_level(input logic [CH_W-1:0] ch, input logic [PCT_W-1:0] pct);
    int unsigned d;
    if (ch >= CHANNELS) return;
    if (pct < PCT_OFF_BELOW) begin
      chan_mode[ch]  = MODE_OFF;
      fire_delay[ch] = '0;
    end else if (pct > PCT_ON_ABOVE) begin
      chan_mode[ch]  = MODE_ON;
      fire_delay[ch] = '0;
    end else begin
      d = ((32'(PCT_FULL) - 32'(pct)) * 32'(line_period)) / 32'(PCT_FULL)
          + 32'(zero_pulse >> 1);
      fire_delay[ch] = d[CNT_W-1:0];
      chan_mode[ch]  = (fire_delay[ch] == '0) ? MODE_ON : MODE_DELAYED;
    end
  endfunction

  // A tick moves the crossing counter and then reevaluates every gate.
  function automatic void advance_tick(input logic level, input logic [US_W-1:0] elapsed);
    int unsigned sum;
    int          i;
    if (level && !last_zero) begin
      since_cross = '0;
    end else begin
      sum = 32'(since_cross) + 32'(elapsed);
      since_cross = (sum > 32'(COUNT_MAX)) ? COUNT_MAX : sum[CNT_W-1:0];
    end
    last_zero = level;
    for (i = 0; i < CHANNELS; i++) begin
      case (chan_mode[i])
        MODE_ON: begin
          gates[i] = 1'b1;
        end
        MODE_DELAYED: begin
          if (since_cross == '0) gates[i] = 1'b0;
          else if (since_cross >= fire_delay[i]) gates[i] = 1'b1;
        end
        default: begin
          gates[i] = 1'b0;
        end
      endcase
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      line_period = LINE_PERIOD_RST;
      zero_pulse  = ZERO_PULSE_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_mode[i]  = MODE_OFF;
        fire_delay[i] = '0;
      end
      gates       = '0;
      since_cross = '0;
      last_zero   = 1'b0;
      gate_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_PERIOD: line_period = cfg_wdata;
          REG_ZERO_PULSE:  zero_pulse  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (gate_expect_q.size() == 0) begin
          $error("gate_levels: no result expected, actual %02h", out_item.gate_levels);
          mismatches++;
        end else begin
          want = gate_expect_q.pop_front();
          compared++;
          if (out_item.gate_levels !== want.gate_levels) begin
            $error("gate_levels: expected %02h, actual %02h",
                   want.gate_levels, out_item.gate_levels);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_item.cmd == CMD_SET) apply_level(in_item.channel, in_item.percent);
        else advance_tick(in_item.zero_level, in_item.elapsed_us);
        want.gate_levels = gates;
        gate_expect_q = {gate_expect_q, want};
      end
    end
    fail_count <= mismatches;
    pending    <= gate_expect_q.size();
    checked    <= compared;
  end

endmodule

// File: sim/tb_ac_phase_angle_dimmer_core.sv
// Top of the dimmer core testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module tb_ac_phase_angle_dimmer_core;
  import acpd_pkg::*;

  localparam int CLK_PERIOD   = 10;
  // Pipeline depth of the core; drain adds a small margin on top.
  localparam int PIPE_LAT     = 2;
  localparam int RANDOM_ITEMS = 1750;
  localparam int HOLD_CYCLES  = 300;
  localparam int IN_W         = $bits(acpd_in_t);
  // The limit is 5 ms of simulated time.
  localparam int TIMEOUT_NS   = 5_000_000;

  // Receiver behaviors, each held for a random stretch of cycles.
  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_SPARSE,
    RX_CADENCE
  } rx_style_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [US_W-1:0]      cfg_wdata;

  acpd_stream_if #(.T(acpd_in_t))  in_if ();
  acpd_stream_if #(.T(acpd_out_t)) out_if ();

  int fail_count;
  int pending;
  int checked;

  // Stimulus bookkeeping.
  int              item_total = 0;
  int              set_count = 0;
  int              tick_count = 0;
  int              setting_count = 0;
  int              burst_left = 1;
  bit              gaps_on = 1'b1;
  bit              rx_hold_req = 1'b0;
  logic [US_W-1:0] cur_period;

  always #(CLK_PERIOD / 2) clk = ~clk;

  ac_phase_angle_dimmer_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // The checker sits beside the core and only watches its ports.
  acpd_gate_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_item    (in_if.data),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .out_item   (out_if.data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // Tick item. The fields that a tick ignores carry random values so that the
  // core is seen to ignore them.
  function automatic acpd_in_t make_tick(input logic zl, input logic [US_W-1:0] el);
    acpd_in_t it;
    it            = IN_W'($urandom);
    it.cmd        = CMD_TICK;
    it.zero_level = zl;
    it.elapsed_us = el;
    return it;
  endfunction

  // Set item, again with random content in the unused fields.
  function automatic acpd_in_t make_set(input logic [CH_W-1:0] ch, input logic [PCT_W-1:0] pct);
    acpd_in_t it;
    it         = IN_W'($urandom);
    it.cmd     = CMD_SET;
    it.channel = ch;
    it.percent = pct;
    return it;
  endfunction

  // Mostly levels in the delayed band, now and then anything the field allows.
  function automatic logic [PCT_W-1:0] pick_percent();
    if ($urandom_range(0, 3) != 0) return PCT_W'($urandom_range(10, 90));
    return PCT_W'($urandom_range(0, 255));
  endfunction

  // Offers one item and returns at the edge of its transfer. In burst mode a
  // random gap follows the last item of each burst, with garbage on the bus.
  task automatic offer(input acpd_in_t item);
    in_if.valid <= 1'b1;
    in_if.data  <= item;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    item_total++;
    if (item.cmd == CMD_SET) set_count++;
    else tick_count++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_if.valid <= 1'b0;
        in_if.data  <= IN_W'($urandom);
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // Stops offering and waits until every expected result has been checked,
  // then lets the pipeline settle before any register write.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // Writes the line period, then the pulse width; the core must be idle.
  task automatic configure(input logic [US_W-1:0] period, input logic [US_W-1:0] pulse);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_PERIOD;
    cfg_wdata <= period;
    @(posedge clk);
    cfg_index <= REG_ZERO_PULSE;
    cfg_wdata <= pulse;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= US_W'($urandom);
    cur_period = period;
    setting_count++;
  endtask

  // One phase of random traffic: every channel gets a level, then half waves
  // follow. Each half wave opens with a rising zero-cross sample, may hold the
  // detector high for a few ticks, and then counts up in steps scaled to the
  // line period so that the delays are crossed. Set items and noise ticks
  // are mixed in.
  task automatic random_phase(input int n_items);
    int phase_end;
    int n_ticks;
    int max_step;
    int i;
    phase_end = item_total + n_items;
    max_step  = int'(cur_period) / 8 + 2;
    for (i = 0; i < CHANNELS_DEF; i++) offer(make_set(CH_W'(i), pick_percent()));
    while (item_total < phase_end) begin
      offer(make_tick(1'b1, US_W'($urandom)));
      repeat ($urandom_range(0, 2)) offer(make_tick(1'b1, US_W'($urandom_range(0, 300))));
      n_ticks = $urandom_range(4, 24);
      for (i = 0; i < n_ticks; i++) begin
        case ($urandom_range(0, 19))
          0, 1: offer(make_set(CH_W'($urandom), pick_percent()));
          2:    offer(make_tick(1'($urandom), US_W'($urandom)));
          default: offer(make_tick(1'b0, US_W'($urandom_range(0, max_step))));
        endcase
      end
    end
  endtask

  // Receiver: random stall styles over random stretches; on request it holds
  // ready low for a long stretch counted here, so the core fills up.
  initial begin
    rx_style_t rx_style;
    int        stretch;
    int        k;
    forever begin
      if (rx_hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        rx_style = rx_style_t'($urandom_range(0, 3));
        stretch  = $urandom_range(20, 200);
        for (k = 0; k < stretch && !rx_hold_req; k++) begin
          case (rx_style)
            RX_STEADY:  out_if.ready <= 1'b1;
            RX_COIN:    out_if.ready <= 1'($urandom);
            RX_SPARSE:  out_if.ready <= ($urandom_range(0, 3) == 0);
            default:    out_if.ready <= (k % 3 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Hard limit on the run.
  initial begin
    #(TIMEOUT_NS);
    $display("Run timed out with %0d results still expected.", pending);
    $display("Verification failed");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int phase;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_wdata    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the power-up period, without gaps.
    gaps_on = 1'b0;
    configure(LINE_PERIOD_RST, ZERO_PULSE_RST);

    // Band edges on each channel: off, first and last delayed level, fully on,
    // and a percent far above 100.
    offer(make_set(3'd0, 8'd0));
    offer(make_set(3'd1, 8'd9));
    offer(make_set(3'd2, 8'd10));
    offer(make_set(3'd3, 8'd50));
    offer(make_set(3'd4, 8'd90));
    offer(make_set(3'd5, 8'd91));
    offer(make_set(3'd6, 8'd100));
    offer(make_set(3'd7, 8'd255));

    // A rising edge ignores elapsed time; the counter then passes the 1000,
    // 5000 and 9000 us delays and saturates on long ticks.
    offer(make_tick(1'b1, 16'hFFFF));
    offer(make_tick(1'b1, 16'd5000));
    offer(make_tick(1'b0, 16'd4000));
    offer(make_tick(1'b0, 16'hFFFF));
    offer(make_tick(1'b0, 16'hFFFF));
    offer(make_tick(1'b0, 16'hFFFF));
    // New crossing: delayed gates drop, and a zero step keeps them low.
    offer(make_tick(1'b1, 16'd0));
    offer(make_tick(1'b0, 16'd0));
    offer(make_tick(1'b0, 16'd1000));

    // Level changes show up only at the next tick.
    offer(make_set(3'd3, 8'd95));
    offer(make_set(3'd4, 8'd5));
    offer(make_tick(1'b0, 16'd1));
    drain();

    // A zero line period gives a zero delay, which means fully on.
    configure('0, '0);
    offer(make_set(3'd2, 8'd50));
    offer(make_set(3'd3, 8'd10));
    offer(make_tick(1'b0, 16'd0));
    drain();

    // Random phases: the register extremes first, then random settings.
    phase = 0;
    while (item_total < RANDOM_ITEMS) begin
      case (phase)
        0:       configure(16'hFFFF, 16'hFFFF);
        1:       configure(16'd1, 16'd1);
        2:       configure(16'd0, 16'hFFFF);
        3:       configure(16'hFFFF, 16'd0);
        4:       configure(LINE_PERIOD_RST, 16'd201);
        5:       configure(US_W'($urandom), US_W'($urandom));
        default: configure(US_W'($urandom_range(100, 20000)), US_W'($urandom_range(0, 2000)));
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      // In one phase the receiver stops for a long stretch while items keep
      // coming, so both pipeline stages fill and the input backs up.
      if (phase == 2) begin
        gaps_on     = 1'b0;
        rx_hold_req = 1'b1;
      end
      random_phase($urandom_range(120, 230));
      drain();
      phase++;
    end

    $display("Ran %0d set items and %0d ticks over %0d register settings.",
             set_count, tick_count, setting_count);
    $display("Compared %0d results, %0d mismatches.", checked, fail_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
